[rtl/blhm_pkg.sv]
// Shared types and constants of the battery level hysteresis monitor.
`timescale 1ns / 1ps

package blhm_pkg;

    // Field widths.
    localparam int VOLT_W    = 13;
    localparam int DROP_W    = 10;
    localparam int COUNT_W   = 8;
    localparam int VADJ_W    = 14;
    localparam int LIMIT_W   = 8;
    localparam int COMP_W    = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    // Serial front end: the adjusted voltage is built two bits per cycle.
    localparam int DIGIT_W    = 2;
    localparam int NUM_DIGITS = VADJ_W / DIGIT_W;

    // Divider: a 22-bit dividend giving a 9-bit quotient, one bit per cycle.
    localparam int NUM_W  = 22;
    localparam int QUOT_W = 9;
    localparam int REM_W  = VADJ_W;

    // Compensation factor limits in Q1.8.
    localparam logic [COMP_W-1:0] COMP_ONE  = 9'd256;
    localparam logic [COMP_W-1:0] COMP_HALF = 9'd128;

    // Thresholds compared against the adjusted voltage.
    localparam int NUM_THR        = 7;
    localparam int THR_CUTOFF     = 0;
    localparam int THR_CRITICAL   = 1;
    localparam int THR_LOW        = 2;
    localparam int THR_CRIT_EXIT  = 3;
    localparam int THR_CUTOFF_EXIT = 4;
    localparam int THR_REF        = 5;
    localparam int THR_PROG       = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_EXIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_EXIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DROP        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_SAMPLES = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE   = 3'd7;

    typedef logic [VOLT_W-1:0] thr_word_t;

    typedef enum logic [1:0] {
        LVL_NORMAL   = 2'd0,
        LVL_LOW      = 2'd1,
        LVL_CRITICAL = 2'd2,
        LVL_CUTOFF   = 2'd3
    } level_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SERIAL,
        ST_DIVIDE,
        ST_HOLD
    } ctrl_state_t;

    // Comparison results of the adjusted voltage v against each threshold t.
    typedef struct packed {
        logic [NUM_THR-1:0] lt;   // v < t
        logic [NUM_THR-1:0] gt;   // v > t
    } cmp_flags_t;

endpackage

[rtl/blhm_serial.sv]
// Digit-serial adder and threshold comparators for the adjusted voltage.
`timescale 1ns / 1ps

module blhm_serial
    import blhm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [VOLT_W-1:0]   voltage_mv,
    input  logic [DROP_W-1:0]   drop_mv,
    input  thr_word_t           thresh [NUM_THR],
    output logic                done,
    output logic [VADJ_W-1:0]   vadj,
    output cmp_flags_t          flags
);

    localparam int CNT_W = $clog2(NUM_DIGITS);
    localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(NUM_DIGITS - 1);

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [VADJ_W-1:0]   volt_sh_reg;
    logic [VADJ_W-1:0]   drop_sh_reg;
    logic [VADJ_W-1:0]   sum_sh_reg;
    logic [VADJ_W-1:0]   thr_sh_reg [NUM_THR];
    logic                carry_reg;
    cmp_flags_t          flags_reg;

    logic [DIGIT_W:0]    digit_sum;
    logic [DIGIT_W-1:0]  sum_digit;
    cmp_flags_t          flags_step;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_DIGIT)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Least significant digit first: each comparison keeps the verdict of the
    // lower digits unless the current digits differ.
    always_comb
    begin
        digit_sum = {1'b0, volt_sh_reg[DIGIT_W-1:0]} + {1'b0, drop_sh_reg[DIGIT_W-1:0]}
                    + {{DIGIT_W{1'b0}}, carry_reg};
        sum_digit = digit_sum[DIGIT_W-1:0];
        for (int i = 0; i < NUM_THR; i++)
        begin
            flags_step.lt[i] = (sum_digit < thr_sh_reg[i][DIGIT_W-1:0])
                || ((sum_digit == thr_sh_reg[i][DIGIT_W-1:0]) && flags_reg.lt[i]);
            flags_step.gt[i] = (sum_digit > thr_sh_reg[i][DIGIT_W-1:0])
                || ((sum_digit == thr_sh_reg[i][DIGIT_W-1:0]) && flags_reg.gt[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            volt_sh_reg <= {{(VADJ_W-VOLT_W){1'b0}}, voltage_mv};
            drop_sh_reg <= {{(VADJ_W-DROP_W){1'b0}}, drop_mv};
            carry_reg   <= 1'b0;
            flags_reg   <= '0;
            for (int i = 0; i < NUM_THR; i++)
            begin
                thr_sh_reg[i] <= {{(VADJ_W-VOLT_W){1'b0}}, thresh[i]};
            end
        end
        else if (run_reg)
        begin
            volt_sh_reg <= volt_sh_reg >> DIGIT_W;
            drop_sh_reg <= drop_sh_reg >> DIGIT_W;
            sum_sh_reg  <= {sum_digit, sum_sh_reg[VADJ_W-1:DIGIT_W]};
            carry_reg   <= digit_sum[DIGIT_W];
            flags_reg   <= flags_step;
            for (int i = 0; i < NUM_THR; i++)
            begin
                thr_sh_reg[i] <= thr_sh_reg[i] >> DIGIT_W;
            end
        end
    end

    assign done  = done_reg;
    assign vadj  = sum_sh_reg;
    assign flags = flags_reg;

endmodule

[rtl/blhm_div.sv]
// Restoring divider for the rounded compensation quotient, one bit per cycle.
`timescale 1ns / 1ps

module blhm_div
    import blhm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [VOLT_W-1:0]   reference_mv,
    input  logic [VADJ_W-1:0]   vadj,
    output logic                done,
    output logic [QUOT_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(QUOT_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUOT_W - 1);

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [VADJ_W-1:0]   div_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [QUOT_W-1:0]   low_reg;
    logic [QUOT_W-1:0]   quot_reg;

    logic [NUM_W-1:0]    num_start;
    logic [REM_W:0]      trial;
    logic [REM_W:0]      diff;
    logic                fits;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Dividend is reference * 256 plus half the divisor, which rounds to
    // nearest with ties up. The quotient is below 512 whenever it is used.
    always_comb
    begin
        num_start = {1'b0, reference_mv, 8'b0} + NUM_W'(vadj >> 1);
        trial     = {rem_reg, low_reg[QUOT_W-1]};
        diff      = trial - {1'b0, div_reg};
        fits      = (trial >= {1'b0, div_reg});
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg  <= vadj;
            rem_reg  <= REM_W'(num_start[NUM_W-1:QUOT_W]);
            low_reg  <= num_start[QUOT_W-1:0];
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg  <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
            low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

[rtl/battery_level_hysteresis_monitor_unit.sv]
// Top level of the battery level monitor: registers, level state machine, output stage.
`timescale 1ns / 1ps

// A request is taken only in the idle state. It passes through the two-bit serial
// adder and comparators, then the one-bit-per-cycle restoring divider, and then waits
// in a hold state until the output register is free; only then is the next one taken.
// A finished result waits in the output register while the next request is taken.
// Reset (asynchronous, active low) sets the level to normal, the run count to zero
// and every configuration register to its default.

module battery_level_hysteresis_monitor_unit
    import blhm_pkg::*;
#(
    parameter int PROG_MODE_MV   = 4500,
    parameter int PROG_PWM       = 128,
    parameter int FULL_LEVEL     = 255,
    parameter int CRITICAL_LEVEL = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VOLT_W-1:0]     voltage_mv,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            level,
    output logic                  level_changed,
    output logic [LIMIT_W-1:0]    brightness_limit,
    output logic [COMP_W-1:0]     comp_factor
);

    localparam logic [COMP_W-1:0]  PROG_COMP   = COMP_W'(((PROG_PWM * 256) + 127) / 255);
    localparam logic [VOLT_W-1:0]  PROG_MV     = VOLT_W'(PROG_MODE_MV);
    localparam logic [LIMIT_W-1:0] FULL_LIM    = LIMIT_W'(FULL_LEVEL);
    localparam logic [LIMIT_W-1:0] CRIT_LIM    = LIMIT_W'(CRITICAL_LEVEL);
    localparam logic [COUNT_W-1:0] RUN_MAX     = '1;

    // Configuration registers.
    logic [VOLT_W-1:0]   cutoff_reg, critical_reg, low_reg, crit_exit_reg;
    logic [VOLT_W-1:0]   cutoff_exit_reg, reference_reg;
    logic [DROP_W-1:0]   drop_reg;
    logic [COUNT_W-1:0]  crit_samples_reg;

    ctrl_state_t         state_reg, state_next;
    level_t              level_reg, level_next;
    logic [COUNT_W-1:0]  run_reg, run_next;
    logic                changed_reg;
    logic                gt_ref_reg;
    logic                gt_prog_reg;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_level_reg;
    logic                out_changed_reg;
    logic [LIMIT_W-1:0]  out_limit_reg;
    logic [COMP_W-1:0]   out_comp_reg;

    logic                ser_start, ser_done, div_start, div_done, out_load, slot_free;
    logic [VADJ_W-1:0]   vadj;
    cmp_flags_t          flags;
    thr_word_t           thresh [NUM_THR];
    logic [QUOT_W-1:0]   quotient;
    logic [COUNT_W-1:0]  run_inc;
    logic [COMP_W-1:0]   comp_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg       <= 13'd3000;
            critical_reg     <= 13'd3200;
            low_reg          <= 13'd3400;
            crit_exit_reg    <= 13'd3300;
            cutoff_exit_reg  <= 13'd3100;
            drop_reg         <= 10'd100;
            crit_samples_reg <= 8'd3;
            reference_reg    <= 13'd3500;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CUTOFF:       cutoff_reg       <= cfg_data;
                REG_CRITICAL:     critical_reg     <= cfg_data;
                REG_LOW:          low_reg          <= cfg_data;
                REG_CRIT_EXIT:    crit_exit_reg    <= cfg_data;
                REG_CUTOFF_EXIT:  cutoff_exit_reg  <= cfg_data;
                REG_DROP:         drop_reg         <= cfg_data[DROP_W-1:0];
                REG_CRIT_SAMPLES: crit_samples_reg <= cfg_data[COUNT_W-1:0];
                REG_REFERENCE:    reference_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        thresh[THR_CUTOFF]      = cutoff_reg;
        thresh[THR_CRITICAL]    = critical_reg;
        thresh[THR_LOW]         = low_reg;
        thresh[THR_CRIT_EXIT]   = crit_exit_reg;
        thresh[THR_CUTOFF_EXIT] = cutoff_exit_reg;
        thresh[THR_REF]         = reference_reg;
        thresh[THR_PROG]        = PROG_MV;
    end

    blhm_serial u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (ser_start),
        .voltage_mv (voltage_mv),
        .drop_mv    (drop_reg),
        .thresh     (thresh),
        .done       (ser_done),
        .vadj       (vadj),
        .flags      (flags)
    );

    blhm_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .reference_mv (reference_reg),
        .vadj         (vadj),
        .done         (div_done),
        .quotient     (quotient)
    );

    // Control sequence: next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_SERIAL;
            ST_SERIAL: if (ser_done) state_next = ST_DIVIDE;
            ST_DIVIDE: if (div_done) state_next = ST_HOLD;
            ST_HOLD:   if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control sequence: outputs.
    always_comb
    begin
        in_ready  = 1'b0;
        ser_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                ser_start = in_valid;
            end
            ST_SERIAL: div_start = ser_done;
            ST_HOLD:   out_load  = slot_free;
            default:   ;
        endcase
    end

    assign slot_free = !out_valid_reg || out_ready;

    // Level update once the comparisons are in.
    always_comb
    begin
        run_inc    = (run_reg == RUN_MAX) ? RUN_MAX : run_reg + 1'b1;
        level_next = level_reg;
        run_next   = run_reg;
        if (ser_done)
        begin
            case (level_reg)
                LVL_NORMAL, LVL_LOW:
                begin
                    if (flags.lt[THR_CUTOFF])
                    begin
                        level_next = LVL_CUTOFF;
                        run_next   = '0;
                    end
                    else if (flags.lt[THR_CRITICAL])
                    begin
                        run_next = run_inc;
                        if (run_inc >= crit_samples_reg)
                        begin
                            level_next = LVL_CRITICAL;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                        if (level_reg == LVL_NORMAL)
                        begin
                            if (flags.lt[THR_LOW])
                            begin
                                level_next = LVL_LOW;
                            end
                        end
                        else if (!flags.lt[THR_LOW])
                        begin
                            level_next = LVL_NORMAL;
                        end
                    end
                end
                LVL_CRITICAL:
                begin
                    if (flags.lt[THR_CUTOFF])
                    begin
                        level_next = LVL_CUTOFF;
                        run_next   = '0;
                    end
                    else if (!flags.lt[THR_CRIT_EXIT])
                    begin
                        level_next = LVL_LOW;
                        run_next   = '0;
                    end
                end
                default:
                begin
                    if (!flags.lt[THR_CUTOFF_EXIT])
                    begin
                        level_next = LVL_CRITICAL;
                        run_next   = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            level_reg     <= LVL_NORMAL;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_done)
        begin
            changed_reg <= (level_next != level_reg);
            gt_ref_reg  <= flags.gt[THR_REF];
            gt_prog_reg <= flags.gt[THR_PROG];
        end
    end

    // Above the programming-mode voltage the factor is fixed; at or below the
    // reference it is one; between them the quotient is clamped to 0.5..1.0.
    always_comb
    begin
        if (gt_prog_reg)
        begin
            comp_value = PROG_COMP;
        end
        else if (!gt_ref_reg)
        begin
            comp_value = COMP_ONE;
        end
        else if (quotient > COMP_ONE)
        begin
            comp_value = COMP_ONE;
        end
        else if (quotient < COMP_HALF)
        begin
            comp_value = COMP_HALF;
        end
        else
        begin
            comp_value = quotient;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_level_reg   <= level_reg;
            out_changed_reg <= changed_reg;
            out_limit_reg   <= (level_reg == LVL_CRITICAL) ? CRIT_LIM : FULL_LIM;
            out_comp_reg    <= comp_value;
        end
    end

    assign out_valid        = out_valid_reg;
    assign level            = out_level_reg;
    assign level_changed    = out_changed_reg;
    assign brightness_limit = out_limit_reg;
    assign comp_factor      = out_comp_reg;

`ifndef NO_ASSERTIONS
    a_ser_done_in_serial : assert property (@(posedge clk) disable iff (!rst_n)
        ser_done |-> state_reg == ST_SERIAL)
        else $error("serial unit finished outside the serial phase");

    a_div_done_in_divide : assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside the divide phase");

    a_one_request_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while one is in progress");

    a_level_only_on_update : assert property (@(posedge clk) disable iff (!rst_n)
        !ser_done |=> $stable(level_reg))
        else $error("level moved without a finished comparison");

    a_comp_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (comp_factor >= COMP_HALF) && (comp_factor <= COMP_ONE))
        else $error("compensation factor outside 0.5 to 1.0");
`endif

endmodule

[verif/blhm_checker.sv]
// Checker for the battery level monitor: predicts each sample's result and compares it.
`timescale 1ns / 1ps

module blhm_checker
    import blhm_pkg::*;
#(
    parameter int PROG_MODE_MV   = 4500,
    parameter int PROG_PWM       = 128,
    parameter int FULL_LEVEL     = 255,
    parameter int CRITICAL_LEVEL = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data,

    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [VOLT_W-1:0]     voltage_mv,

    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [1:0]            level,
    input  logic                  level_changed,
    input  logic [LIMIT_W-1:0]    brightness_limit,
    input  logic [COMP_W-1:0]     comp_factor,

    output int                    fail_count,
    output int                    outstanding
);

    typedef struct {
        level_t              lvl;
        logic                changed;
        logic [LIMIT_W-1:0]  limit;
        logic [COMP_W-1:0]   comp;
    } sample_result_t;

    sample_result_t pending_results[$];
    sample_result_t want;

    // Shadow copy of the configuration registers.
    thr_word_t          thr_cutoff;
    thr_word_t          thr_critical;
    thr_word_t          thr_low;
    thr_word_t          thr_crit_exit;
    thr_word_t          thr_cutoff_exit;
    logic [DROP_W-1:0]  drop_offset;
    logic [COUNT_W-1:0] samples_needed;
    thr_word_t          ref_mv;

    // Predicted state of the level machine.
    level_t             cur_level;
    logic [COUNT_W-1:0] band_run;

    initial fail_count = 0;

    function automatic logic [COMP_W-1:0] comp_for(input logic [VADJ_W-1:0] v);
        logic [31:0] q;
        if (v > PROG_MODE_MV)
            return COMP_W'((PROG_PWM * 256 + 127) / 255);
        if (v <= ref_mv)
            return COMP_ONE;
        q = (32'(ref_mv) * 32'd256 + 32'(v >> 1)) / 32'(v);
        if (q > 32'(COMP_ONE))
            q = 32'(COMP_ONE);
        if (q < 32'(COMP_HALF))
            q = 32'(COMP_HALF);
        return q[COMP_W-1:0];
    endfunction

    // Advances the level machine by one sample and returns the result it produces.
    function automatic sample_result_t advance_level(input logic [VOLT_W-1:0] mv);
        logic [VADJ_W-1:0] v;
        level_t            prev;
        sample_result_t    r;
        v    = VADJ_W'(mv) + VADJ_W'(drop_offset);
        prev = cur_level;
        case (prev)
            LVL_NORMAL, LVL_LOW:
            begin
                if (v < thr_cutoff)
                begin
                    cur_level = LVL_CUTOFF;
                    band_run  = '0;
                end
                else if (v < thr_critical)
                begin
                    if (band_run != {COUNT_W{1'b1}})
                        band_run = band_run + 1'b1;
                    if (band_run >= samples_needed)
                        cur_level = LVL_CRITICAL;
                end
                else if (prev == LVL_NORMAL)
                begin
                    if (v < thr_low)
                        cur_level = LVL_LOW;
                    band_run = '0;
                end
                else
                begin
                    if (v >= thr_low)
                        cur_level = LVL_NORMAL;
                    band_run = '0;
                end
            end
            LVL_CRITICAL:
            begin
                if (v < thr_cutoff)
                begin
                    cur_level = LVL_CUTOFF;
                    band_run  = '0;
                end
                else if (v >= thr_crit_exit)
                begin
                    cur_level = LVL_LOW;
                    band_run  = '0;
                end
            end
            default:
            begin
                if (v >= thr_cutoff_exit)
                begin
                    cur_level = LVL_CRITICAL;
                    band_run  = '0;
                end
            end
        endcase
        r.lvl     = cur_level;
        r.changed = (cur_level != prev);
        r.limit   = (cur_level == LVL_CRITICAL) ? LIMIT_W'(CRITICAL_LEVEL) : LIMIT_W'(FULL_LEVEL);
        r.comp    = comp_for(v);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [COMP_W-1:0] exp_val,
                               input logic [COMP_W-1:0] got);
        if (got !== exp_val)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_cutoff      = 13'd3000;
            thr_critical    = 13'd3200;
            thr_low         = 13'd3400;
            thr_crit_exit   = 13'd3300;
            thr_cutoff_exit = 13'd3100;
            drop_offset     = 10'd100;
            samples_needed  = 8'd3;
            ref_mv          = 13'd3500;
            cur_level       = LVL_NORMAL;
            band_run        = '0;
            pending_results.delete();
            outstanding    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CUTOFF:       thr_cutoff      = cfg_data;
                    REG_CRITICAL:     thr_critical    = cfg_data;
                    REG_LOW:          thr_low         = cfg_data;
                    REG_CRIT_EXIT:    thr_crit_exit   = cfg_data;
                    REG_CUTOFF_EXIT:  thr_cutoff_exit = cfg_data;
                    REG_DROP:         drop_offset     = cfg_data[DROP_W-1:0];
                    REG_CRIT_SAMPLES: samples_needed  = cfg_data[COUNT_W-1:0];
                    REG_REFERENCE:    ref_mv          = cfg_data;
                    default:          ;
                endcase
            end
            if (in_valid && in_ready)
                pending_results.push_back(advance_level(voltage_mv));
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t ns: result with no request waiting, expected none, got level %0d comp %0d",
                             $time, level, comp_factor);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("level", COMP_W'(want.lvl), COMP_W'(level));
                    check_field("level_changed", COMP_W'(want.changed), COMP_W'(level_changed));
                    check_field("brightness_limit", COMP_W'(want.limit), COMP_W'(brightness_limit));
                    check_field("comp_factor", want.comp, comp_factor);
                end
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

[verif/tb.sv]
// Testbench top for the battery level monitor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import blhm_pkg::*;

    localparam int VOLT_MAX    = (1 << VOLT_W) - 1;
    localparam int PROG_MV     = 4500;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 4000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DAT_W-1:0]  cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [VOLT_W-1:0]     voltage_mv;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            level;
    logic                  level_changed;
    logic [LIMIT_W-1:0]    brightness_limit;
    logic [COMP_W-1:0]     comp_factor;

    int fail_count;
    int outstanding;
    int tx_idle_pct;
    int rx_stall_pct;
    int idle_cycles;
    int hold_left;
    logic hold_req;

    // Copy of the programmed configuration, used to aim samples at the thresholds.
    int cur_cutoff, cur_critical, cur_low, cur_crit_exit, cur_cutoff_exit;
    int cur_drop, cur_samples, cur_ref;

    battery_level_hysteresis_monitor_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .voltage_mv       (voltage_mv),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .level            (level),
        .level_changed    (level_changed),
        .brightness_limit (brightness_limit),
        .comp_factor      (comp_factor)
    );

    blhm_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .voltage_mv       (voltage_mv),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .level            (level),
        .level_changed    (level_changed),
        .brightness_limit (brightness_limit),
        .comp_factor      (comp_factor),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Result side: random stalls, or a long hold-off when the stimulus asks for one.
    initial
    begin
        out_ready <= 1'b0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("battery_level_hysteresis_monitor_unit regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_sample(input logic [VOLT_W-1:0] mv);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        voltage_mv <= mv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DAT_W'(data);
        @(posedge clk);
    endtask

    task automatic load_config(input int cutoff, input int critical, input int low_thr,
                               input int crit_exit, input int cutoff_exit, input int drop,
                               input int samples, input int ref_set);
        cur_cutoff      = cutoff;
        cur_critical    = critical;
        cur_low         = low_thr;
        cur_crit_exit   = crit_exit;
        cur_cutoff_exit = cutoff_exit;
        cur_drop        = drop;
        cur_samples     = samples;
        cur_ref         = ref_set;
        put_reg(REG_CUTOFF, cutoff);
        put_reg(REG_CRITICAL, critical);
        put_reg(REG_LOW, low_thr);
        put_reg(REG_CRIT_EXIT, crit_exit);
        put_reg(REG_CUTOFF_EXIT, cutoff_exit);
        put_reg(REG_DROP, drop);
        put_reg(REG_CRIT_SAMPLES, samples);
        put_reg(REG_REFERENCE, ref_set);
        cfg_we <= 1'b0;
    endtask

    // A raw sample whose adjusted voltage lies in the band that counts toward critical,
    // or -1 when the band is empty.
    function automatic int band_voltage();
        int lo;
        int hi;
        lo = cur_cutoff - cur_drop;
        hi = cur_critical - 1 - cur_drop;
        if (lo < 0)
            lo = 0;
        if (hi > VOLT_MAX)
            hi = VOLT_MAX;
        if (hi < lo)
            return -1;
        return int'($urandom_range(lo, hi));
    endfunction

    function automatic logic [VOLT_W-1:0] pick_voltage();
        int r;
        int thr;
        int target;
        r = $urandom_range(0, 99);
        if (r < 15)
            return VOLT_W'($urandom_range(0, VOLT_MAX));
        if (r < 20)
            return r[0] ? VOLT_W'(VOLT_MAX) : '0;
        case ($urandom_range(0, 6))
            0:       thr = cur_cutoff;
            1:       thr = cur_critical;
            2:       thr = cur_low;
            3:       thr = cur_crit_exit;
            4:       thr = cur_cutoff_exit;
            5:       thr = cur_ref;
            default: thr = PROG_MV;
        endcase
        target = thr - cur_drop + int'($urandom_range(0, 80)) - 40;
        if (target < 0)
            target = 0;
        if (target > VOLT_MAX)
            target = VOLT_MAX;
        return VOLT_W'(target);
    endfunction

    // Mostly single samples near the thresholds, with runs in the critical band
    // long enough to reach the critical level.
    task automatic run_random(input int n);
        int sent;
        int run_len;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 4) == 0 && band_voltage() >= 0)
            begin
                run_len = (cur_samples > 12) ? 14 : cur_samples + 2;
                repeat (run_len)
                begin
                    send_sample(VOLT_W'(band_voltage()));
                    sent++;
                end
            end
            else
            begin
                send_sample(pick_voltage());
                sent++;
            end
        end
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    initial
    begin
        int unsigned directed_mv [15];
        int base;
        int crit;
        int lowb;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        voltage_mv <= '0;
        hold_req    = 1'b0;
        idle_cycles = 0;
        set_idling(0, 0);
        cur_cutoff      = 3000;
        cur_critical    = 3200;
        cur_low         = 3400;
        cur_crit_exit   = 3300;
        cur_cutoff_exit = 3100;
        cur_drop        = 100;
        cur_samples     = 3;
        cur_ref         = 3500;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Enter and leave every level under the reset configuration, plus the field extremes
        // and both sides of the programming-mode cap.
        directed_mv = '{3500, 3250, 3050, 3050, 3050, 3300, 2800, 2950,
                        3000, 3150, 3250, 8191, 0, 4400, 4401};
        foreach (directed_mv[i])
            send_sample(VOLT_W'(directed_mv[i]));
        wait_idle();

        // Every threshold at the top: anything below it cuts off, and recovery
        // needs the largest value.
        load_config(VOLT_MAX, VOLT_MAX, VOLT_MAX, VOLT_MAX, VOLT_MAX, 0, 1, VOLT_MAX);
        send_sample(VOLT_W'(VOLT_MAX));
        send_sample('0);
        send_sample(VOLT_W'(VOLT_MAX));
        send_sample(VOLT_W'(VOLT_MAX));
        send_sample(VOLT_W'(VOLT_MAX));
        wait_idle();

        // Every threshold at zero with a zero reference voltage.
        load_config(0, 0, 0, 0, 0, 0, 0, 0);
        send_sample('0);
        send_sample(VOLT_W'(1));
        send_sample(VOLT_W'(PROG_MV));
        send_sample(VOLT_W'(PROG_MV + 1));
        wait_idle();

        // Defaults again, with a long hold-off on the result side so the block backs up.
        load_config(3000, 3200, 3400, 3300, 3100, 100, 3, 3500);
        set_idling(0, 0);
        hold_req = 1'b1;
        run_random(40);
        wait_idle();

        load_config(1000, 2000, 3000, 2500, 1500, 0, 1, VOLT_MAX);
        set_idling(45, 0);
        run_random(40);
        wait_idle();

        // Unordered thresholds, largest drop, zero sample count and zero reference.
        load_config(5000, 4000, 6000, VOLT_MAX, 0, 1023, 0, 0);
        set_idling(0, 45);
        run_random(40);
        wait_idle();

        base = $urandom_range(1500, 6000);
        crit = base + int'($urandom_range(1, 300));
        lowb = crit + int'($urandom_range(0, 300));
        load_config(base, crit, lowb, int'($urandom_range(base, lowb)),
                    int'($urandom_range(base, crit)), int'($urandom_range(0, 1023)),
                    int'($urandom_range(1, 8)), int'($urandom_range(1, VOLT_MAX)));
        set_idling(12, 12);
        run_random(40);
        wait_idle();

        // A long dwell in the critical band with the largest sample count, so the
        // run counter climbs to its top.
        load_config(500, 7000, 7500, VOLT_MAX, 0, 0, 255, 3500);
        set_idling(12, 12);
        repeat (258)
            send_sample(VOLT_W'(band_voltage()));
        wait_idle();

        load_config(int'($urandom_range(0, VOLT_MAX)), int'($urandom_range(0, VOLT_MAX)),
                    int'($urandom_range(0, VOLT_MAX)), int'($urandom_range(0, VOLT_MAX)),
                    int'($urandom_range(0, VOLT_MAX)), int'($urandom_range(0, 1023)),
                    int'($urandom_range(0, 6)), int'($urandom_range(0, VOLT_MAX)));
        set_idling(45, 0);
        run_random(40);

        wait_idle();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("battery_level_hysteresis_monitor_unit regression: pass");
        else
            $display("battery_level_hysteresis_monitor_unit regression: fail");
        $finish;
    end

endmodule

[battery_level_hysteresis_monitor_unit.f]
rtl/blhm_pkg.sv
rtl/blhm_serial.sv
rtl/blhm_div.sv
rtl/battery_level_hysteresis_monitor_unit.sv
verif/blhm_checker.sv
verif/tb.sv
